### src/l1bp_pkg.sv
// Package for the L1 ball projection unit: widths, reset values, controller
// states, command and status structs, and the magnitude function.
// No dependencies.
`default_nettype none
package l1bp_pkg;

	localparam int VALUE_BITS = 32;
	localparam int MAX_LEN    = 64;
	localparam int IDX_W      = $clog2(MAX_LEN);
	localparam int CNT_W      = IDX_W + 1;
	localparam int MAG_W      = VALUE_BITS + 1;
	localparam int SUM_W      = VALUE_BITS + 7;
	localparam int DCNT_W     = $clog2(SUM_W);
	localparam logic [31:0] RADIUS_RESET = 32'd4194304;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CHECK,
		ST_OUTER_RD,
		ST_AI,
		ST_INNER_RD,
		ST_INNER_ACC,
		ST_OUTER_END,
		ST_DIV_SETUP,
		ST_DIV,
		ST_DIV_END,
		ST_EMIT_RD,
		ST_EMIT_PUT
	} state_t;

	typedef enum logic [1:0] {
		RD_I,
		RD_J,
		RD_K
	} rd_sel_t;

	typedef struct packed {
		logic    ld_en;
		logic    clr;
		logic    outer_start;
		logic    ai_load;
		logic    inner_acc;
		logic    outer_end;
		logic    thr_zero;
		logic    thr_top;
		logic    div_start;
		logic    div_step;
		logic    thr_div;
		logic    emit_start;
		logic    emit_put;
		rd_sel_t rd_sel;
	} cmd_t;

	typedef struct packed {
		logic last_elem;
		logic abs_le_r;
		logic j_last;
		logic i_last;
		logic k_last;
		logic best_c_zero;
		logic best_le_r;
		logic div_last;
		logic out_free;
	} sts_t;

	function automatic logic [MAG_W-1:0] magnitude(input logic [VALUE_BITS-1:0] v);
		logic [MAG_W-1:0] ext;
		ext = {v[VALUE_BITS-1], v};
		return v[VALUE_BITS-1] ? (MAG_W'(0) - ext) : ext;
	endfunction

endpackage
`default_nettype wire

### src/l1bp_in_if.sv
// Input stream interface: valid/ready handshake with one vector element.
// Depends on l1bp_pkg.
`default_nettype none
interface l1bp_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [l1bp_pkg::VALUE_BITS-1:0] element_value;
	logic                                 last_in;

	modport source (output valid, output element_value, output last_in, input ready);
	modport sink (input valid, input element_value, input last_in, output ready);
endinterface
`default_nettype wire

### src/l1bp_out_if.sv
// Output stream interface: valid/ready handshake with one projected element.
// Depends on l1bp_pkg.
`default_nettype none
interface l1bp_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [l1bp_pkg::VALUE_BITS-1:0] projected_value;
	logic                                 last_out;

	modport source (output valid, output projected_value, output last_out, input ready);
	modport sink (input valid, input projected_value, input last_out, output ready);
endinterface
`default_nettype wire

### src/l1bp_ctrl.sv
// Controller state machine: sequences load, pivot search, division and emit.
// Depends on l1bp_pkg.
`default_nettype none
module l1bp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire l1bp_pkg::sts_t    sts,
	output l1bp_pkg::cmd_t         cmd
);

	l1bp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= l1bp_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_sel = l1bp_pkg::RD_I;
		in_ready   = 1'b0;
		case (state_q)
			l1bp_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld_en = 1'b1;
					if (sts.last_elem) state_d = l1bp_pkg::ST_CHECK;
				end
			end
			l1bp_pkg::ST_CHECK: begin
				if (sts.abs_le_r) begin
					cmd.thr_zero   = 1'b1;
					cmd.emit_start = 1'b1;
					state_d        = l1bp_pkg::ST_EMIT_RD;
				end else begin
					cmd.outer_start = 1'b1;
					state_d         = l1bp_pkg::ST_OUTER_RD;
				end
			end
			l1bp_pkg::ST_OUTER_RD: begin
				cmd.rd_sel = l1bp_pkg::RD_I;
				state_d    = l1bp_pkg::ST_AI;
			end
			l1bp_pkg::ST_AI: begin
				cmd.ai_load = 1'b1;
				state_d     = l1bp_pkg::ST_INNER_RD;
			end
			l1bp_pkg::ST_INNER_RD: begin
				cmd.rd_sel = l1bp_pkg::RD_J;
				state_d    = l1bp_pkg::ST_INNER_ACC;
			end
			l1bp_pkg::ST_INNER_ACC: begin
				cmd.inner_acc = 1'b1;
				state_d = sts.j_last ? l1bp_pkg::ST_OUTER_END : l1bp_pkg::ST_INNER_RD;
			end
			l1bp_pkg::ST_OUTER_END: begin
				cmd.outer_end = 1'b1;
				state_d = sts.i_last ? l1bp_pkg::ST_DIV_SETUP : l1bp_pkg::ST_OUTER_RD;
			end
			l1bp_pkg::ST_DIV_SETUP: begin
				if (sts.best_c_zero) begin
					cmd.thr_top    = 1'b1;
					cmd.emit_start = 1'b1;
					state_d        = l1bp_pkg::ST_EMIT_RD;
				end else if (sts.best_le_r) begin
					cmd.thr_zero   = 1'b1;
					cmd.emit_start = 1'b1;
					state_d        = l1bp_pkg::ST_EMIT_RD;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = l1bp_pkg::ST_DIV;
				end
			end
			l1bp_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = l1bp_pkg::ST_DIV_END;
			end
			l1bp_pkg::ST_DIV_END: begin
				cmd.thr_div    = 1'b1;
				cmd.emit_start = 1'b1;
				state_d        = l1bp_pkg::ST_EMIT_RD;
			end
			l1bp_pkg::ST_EMIT_RD: begin
				cmd.rd_sel = l1bp_pkg::RD_K;
				state_d    = l1bp_pkg::ST_EMIT_PUT;
			end
			l1bp_pkg::ST_EMIT_PUT: begin
				cmd.rd_sel = l1bp_pkg::RD_K;
				if (sts.out_free) begin
					cmd.emit_put = 1'b1;
					if (sts.k_last) begin
						cmd.clr = 1'b1;
						state_d = l1bp_pkg::ST_LOAD;
					end else begin
						state_d = l1bp_pkg::ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = l1bp_pkg::ST_LOAD;
			end
		endcase
	end

endmodule
`default_nettype wire

### src/l1bp_datapath.sv
// Datapath: element store, sums, pivot search registers, restoring divider
// and output register. Depends on l1bp_pkg.
`default_nettype none
module l1bp_datapath (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [31:0]                      cfg_wdata,
	input  wire logic [l1bp_pkg::VALUE_BITS-1:0]  element_value,
	input  wire logic                             last_in,
	input  wire logic                             out_ready,
	input  wire l1bp_pkg::cmd_t                   cmd,
	output l1bp_pkg::sts_t                        sts,
	output logic                                  out_valid,
	output logic [l1bp_pkg::VALUE_BITS-1:0]       projected_value,
	output logic                                  last_out
);

	localparam int VB = l1bp_pkg::VALUE_BITS;
	localparam int MW = l1bp_pkg::MAG_W;
	localparam int SW = l1bp_pkg::SUM_W;
	localparam int IW = l1bp_pkg::IDX_W;
	localparam int CW = l1bp_pkg::CNT_W;
	localparam int DW = l1bp_pkg::DCNT_W;

	logic [VB-1:0] mem_q [l1bp_pkg::MAX_LEN];
	logic [VB-1:0] rdata_q;
	logic [IW-1:0] rd_addr;

	logic [31:0]   radius_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] abs_sum_q;
	logic [IW-1:0] i_q, j_q, k_q;
	logic [MW-1:0] ai_q, top_q;
	logic [SW-1:0] g_q, d_q, best_s_q;
	logic [CW-1:0] c_q, best_c_q;
	logic [SW-1:0] div_q;
	logic [CW-1:0] rem_q;
	logic [DW-1:0] dcnt_q;
	logic [31:0]   thr_q;
	logic          out_vld_q;
	logic [VB-1:0] proj_q;
	logic          last_q;

	logic [SW-1:0] radius_ext;
	logic [IW-1:0] nm1;
	logic [MW-1:0] mag_in, mag_rd, thr_ext, red;
	logic [CW:0]   trial;
	logic          take;
	logic [CW-1:0] rem_sub;

	assign radius_ext = SW'(radius_q);
	assign nm1        = IW'(cnt_q - CW'(1));
	assign mag_in     = l1bp_pkg::magnitude(element_value);
	assign mag_rd     = l1bp_pkg::magnitude(rdata_q);
	assign thr_ext    = MW'(thr_q);
	assign red        = (mag_rd > thr_ext) ? (mag_rd - thr_ext) : '0;
	assign trial      = {rem_q, div_q[SW-1]};
	assign take       = trial >= {1'b0, best_c_q};
	assign rem_sub    = CW'(trial - {1'b0, best_c_q});

	always_comb begin
		case (cmd.rd_sel)
			l1bp_pkg::RD_I: rd_addr = i_q;
			l1bp_pkg::RD_J: rd_addr = j_q;
			l1bp_pkg::RD_K: rd_addr = k_q;
			default:        rd_addr = i_q;
		endcase
	end

	assign sts.last_elem   = last_in || (cnt_q == CW'(l1bp_pkg::MAX_LEN - 1));
	assign sts.abs_le_r    = abs_sum_q <= radius_ext;
	assign sts.j_last      = j_q == nm1;
	assign sts.i_last      = i_q == nm1;
	assign sts.k_last      = k_q == nm1;
	assign sts.best_c_zero = best_c_q == '0;
	assign sts.best_le_r   = best_s_q <= radius_ext;
	assign sts.div_last    = dcnt_q == DW'(SW - 1);
	assign sts.out_free    = !out_vld_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.ld_en) mem_q[cnt_q[IW-1:0]] <= element_value;
		rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= l1bp_pkg::RADIUS_RESET;
			cnt_q     <= '0;
			abs_sum_q <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			c_q       <= '0;
			best_c_q  <= '0;
			dcnt_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) radius_q <= cfg_wdata;
			if (cmd.clr) begin
				cnt_q     <= '0;
				abs_sum_q <= '0;
			end else if (cmd.ld_en) begin
				cnt_q     <= cnt_q + CW'(1);
				abs_sum_q <= abs_sum_q + SW'(mag_in);
			end
			if (cmd.outer_start) begin
				i_q      <= '0;
				best_c_q <= '0;
			end
			if (cmd.ai_load) begin
				j_q <= '0;
				c_q <= '0;
			end
			if (cmd.inner_acc) begin
				j_q <= j_q + IW'(1);
				if (mag_rd >= ai_q) c_q <= c_q + CW'(1);
			end
			if (cmd.outer_end) begin
				i_q <= i_q + IW'(1);
				if ((d_q < radius_ext) && (c_q > best_c_q)) best_c_q <= c_q;
			end
			if (cmd.div_start) dcnt_q <= '0;
			else if (cmd.div_step) dcnt_q <= dcnt_q + DW'(1);
			if (cmd.emit_start) k_q <= '0;
			else if (cmd.emit_put) k_q <= k_q + IW'(1);
			if (cmd.emit_put) out_vld_q <= 1'b1;
			else if (out_ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.outer_start) top_q <= '0;
		if (cmd.ai_load) begin
			ai_q <= mag_rd;
			g_q  <= '0;
			d_q  <= '0;
			if (mag_rd > top_q) top_q <= mag_rd;
		end
		if (cmd.inner_acc && (mag_rd >= ai_q)) begin
			g_q <= g_q + SW'(mag_rd);
			d_q <= d_q + SW'(mag_rd - ai_q);
		end
		if (cmd.outer_end && (d_q < radius_ext) && (c_q > best_c_q)) best_s_q <= g_q;
		if (cmd.div_start) begin
			div_q <= best_s_q - radius_ext;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			div_q <= {div_q[SW-2:0], take};
			rem_q <= take ? rem_sub : CW'(trial);
		end
		if (cmd.thr_zero) thr_q <= '0;
		else if (cmd.thr_top) thr_q <= top_q[31:0];
		else if (cmd.thr_div) thr_q <= div_q[31:0];
		if (cmd.emit_put) begin
			proj_q <= rdata_q[VB-1] ? (VB'(0) - red[VB-1:0]) : red[VB-1:0];
			last_q <= sts.k_last;
		end
	end

	assign out_valid       = out_vld_q;
	assign projected_value = proj_q;
	assign last_out        = last_q;

`ifndef SYNTHESIS
	a_put_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_put |-> (!out_vld_q || out_ready)) else $error("emit over held result");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(l1bp_pkg::MAX_LEN)) else $error("element count overflow");
	a_ld_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_en |-> (cnt_q < CW'(l1bp_pkg::MAX_LEN))) else $error("store full on load");
	a_clr_after: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |=> (cnt_q == '0)) else $error("count not cleared");
`endif

endmodule
`default_nettype wire

### src/l1_ball_projection_unit.sv
// Top level of the L1 ball projection unit: joins controller and datapath.
// Depends on l1bp_pkg, l1bp_in_if, l1bp_out_if, l1bp_ctrl, l1bp_datapath.
//
//   channel   direction  payload
//   in_ch     sink       element_value, last_in
//   out_ch    source     projected_value, last_out
//   cfg       write      cfg_we, cfg_wdata (radius)
//
// Load accepts one element per cycle; a check state then compares the sum with the
// radius. Outside the ball the pivot search uses one store read port, followed by a
// setup state and then the restoring divider unless the threshold is zero or the top.
// Emission reads each element, then puts it out; a stalled output holds emission.
// Reset is asynchronous; the store needs no clearing pass.
// Input is taken only while loading.
`default_nettype none
module l1_ball_projection_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	l1bp_in_if.sink          in_ch,
	l1bp_out_if.source       out_ch
);

	l1bp_pkg::cmd_t cmd;
	l1bp_pkg::sts_t sts;

	l1bp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	l1bp_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.element_value   (in_ch.element_value),
		.last_in         (in_ch.last_in),
		.out_ready       (out_ch.ready),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (out_ch.valid),
		.projected_value (out_ch.projected_value),
		.last_out        (out_ch.last_out)
	);

endmodule
`default_nettype wire

### sim/l1bp_tb_if.sv
// Testbench interface for the radius configuration port: write enable and data.
// No dependencies.
`timescale 1ns / 1ps
interface l1bp_cfg_if;
	logic        we;
	logic [31:0] wdata;
endinterface

### sim/tb_l1_ball_projection_unit.sv
// Testbench for l1_ball_projection_unit: streams vectors, predicts each projection
// with a scoreboard class, and checks every projected element in order.
// Depends on l1bp_pkg, l1bp_in_if, l1bp_out_if, l1bp_cfg_if and the block's RTL.
`timescale 1ns / 1ps
module tb_l1_ball_projection_unit;

	localparam int VB = l1bp_pkg::VALUE_BITS;
	localparam int ML = l1bp_pkg::MAX_LEN;

	typedef struct {
		logic [VB-1:0] value;
		logic          last;
	} proj_t;

	class projection_board;
		logic [31:0]   radius;
		logic [VB-1:0] vec[$];
		proj_t         pending[$];
		int            errors;

		function new();
			radius = l1bp_pkg::RADIUS_RESET;
			errors = 0;
		endfunction

		function logic [63:0] mag(logic [VB-1:0] v);
			return v[VB-1] ? 64'(-$signed({32'hFFFF_FFFF, v})) : 64'(v);
		endfunction

		function void note_element(logic [VB-1:0] v, logic last);
			logic [63:0] total, theta, top, best_c, best_s, g, c, ai, a, r;
			proj_t p;
			vec.insert(vec.size(), v);
			if (!last && vec.size() < ML)
				return;
			total = 0;
			foreach (vec[i]) total += mag(vec[i]);
			theta = 0;
			if (total > radius) begin
				best_c = 0; best_s = 0; top = 0;
				foreach (vec[i]) begin
					ai = mag(vec[i]);
					if (ai > top) top = ai;
					g = 0; c = 0;
					foreach (vec[j]) if (mag(vec[j]) >= ai) begin
						g += mag(vec[j]);
						c++;
					end
					if (g - c * ai < radius && c > best_c) begin
						best_c = c;
						best_s = g;
					end
				end
				if (best_c == 0) theta = top;
				else if (best_s <= radius) theta = 0;
				else theta = (best_s - radius) / best_c;
				theta &= 64'hFFFF_FFFF;
			end
			foreach (vec[k]) begin
				a = mag(vec[k]);
				r = (a > theta) ? a - theta : 0;
				if (vec[k][VB-1]) r = -r;
				p.value = r[VB-1:0];
				p.last = (k == vec.size() - 1);
				pending.insert(pending.size(), p);
			end
			vec.delete();
		endfunction

		function void check_result(logic [VB-1:0] v, logic last);
			proj_t e;
			if (pending.size() == 0) begin
				$error("projected_value unexpected, actual %h", v);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (v !== e.value) begin
				$error("projected_value expected %h actual %h", e.value, v);
				errors++;
			end
			if (last !== e.last) begin
				$error("last_out expected %b actual %b", e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	int          send_idle = 0, recv_stall = 0, quiet = 0;
	projection_board board;

	l1bp_in_if  in_ch();
	l1bp_out_if out_ch();
	l1bp_cfg_if cfg();

	l1_ball_projection_unit i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg.we), .cfg_wdata(cfg.wdata),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	initial begin
		in_ch.valid = 0;
		in_ch.element_value = 0;
		in_ch.last_in = 0;
		out_ch.ready = 0;
		cfg.we = 0;
		cfg.wdata = 0;
		board = new();
	end

	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			board.note_element(in_ch.element_value, in_ch.last_in);
		if (out_ch.valid && out_ch.ready)
			board.check_result(out_ch.projected_value, out_ch.last_out);
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 50000) begin
			$display("tb_l1_ball_projection_unit: errors");
			$finish;
		end
	end

	always @(negedge clk)
		out_ch.ready <= ($urandom_range(99) >= recv_stall);

	task automatic send_element(logic [31:0] v, logic last);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 0;
			@(negedge clk);
		end
		in_ch.valid <= 1;
		in_ch.element_value <= v;
		in_ch.last_in <= last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic set_radius(logic [31:0] r);
		drain();
		cfg.we <= 1;
		cfg.wdata <= r;
		board.radius = r;
		@(negedge clk);
		cfg.we <= 0;
	endtask

	function automatic logic [31:0] rand_value(int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
			default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
		endcase
	endfunction

	task automatic send_vector(int n, int mode);
		for (int i = 0; i < n; i++)
			send_element(rand_value(mode), i == n - 1);
	endtask

	initial begin
		int sent, n;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_element(32'h7FFF_FFFF, 0);
		send_element(32'h8000_0000, 0);
		send_element(32'h0000_0000, 1);
		send_element(32'h0001_0000, 0);
		send_element(32'hFFFF_0000, 1);
		send_element(32'h0010_0000, 0);
		send_element(32'h0010_0000, 0);
		send_element(32'hFFF0_0000, 0);
		send_element(32'h0001_0000, 1);
		send_element(32'h0000_0000, 1);
		set_radius(0);
		send_element(32'h0003_0000, 0);
		send_element(32'hFFFD_0000, 1);
		set_radius(32'hFFFF_FFFF);
		send_element(32'h8000_0000, 0);
		send_element(32'h8000_0000, 1);
		set_radius(32'h0000_0001);
		send_vector(ML, 1);
		sent = 14 + ML;
		for (int ph = 0; sent < 460; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 70; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 70; end
				default: begin send_idle = 32; recv_stall = 32; end
			endcase
			if (ph % 3 == 1)
				set_radius($urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h0040_0000));
			for (int v = 0; v < 6; v++) begin
				n = ($urandom_range(9) == 0) ? ML : $urandom_range(1, 8);
				send_vector(n, $urandom_range(2));
				sent += n;
			end
			if (ph == 2) drain();
		end
		drain();
		if (board.errors == 0)
			$display("tb_l1_ball_projection_unit: clean");
		else
			$display("tb_l1_ball_projection_unit: errors");
		$finish;
	end
endmodule
